/* src/rbst_pkg.sv */
// ----------------------------------------------------------------------------
// rbst_pkg: shared constants for the ray versus box slab test
// Coordinate width, derived arithmetic widths and register map.
// ----------------------------------------------------------------------------
package rbst_pkg;

  // Signed fixed-point coordinate width (Q8.8 at 16 bits)
  localparam int COORD_WIDTH = 16;
  // Corner minus origin needs one extra bit
  localparam int DIFF_W      = COORD_WIDTH + 1;
  // Exact product of a difference and an inverse direction
  localparam int PROD_W      = DIFF_W + COORD_WIDTH;

  localparam int NUM_AXES    = 3;
  localparam int NREG        = 2 * NUM_AXES;

  // APB register map: register i at byte address 4*i
  localparam int APB_DATA_W  = 32;
  localparam int ADDR_W      = $clog2(4 * NREG);
  localparam int IDX_W       = ADDR_W - 2;

  localparam logic [IDX_W-1:0] REG_BOX_MIN_X = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_BOX_MIN_Y = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_BOX_MIN_Z = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_BOX_MAX_X = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_BOX_MAX_Y = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_BOX_MAX_Z = IDX_W'(5);

  // Reset box is empty: lower corner above upper corner
  localparam logic [COORD_WIDTH-1:0] BOX_MIN_RESET = COORD_WIDTH'(32767);
  localparam logic [COORD_WIDTH-1:0] BOX_MAX_RESET = COORD_WIDTH'(-32768);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

endpackage

/* src/ray_box_slab_test_unit.sv */
// ----------------------------------------------------------------------------
// ray_box_slab_test_unit: ray against axis-aligned box, slab test
// Box corners sit in APB registers; one ray per beat gives one hit flag.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                | Payload
//  --------+--------------------------+-----------------------------------------
//  input   | in_valid / in_ready      | origin_x/y/z, inv_dir_x/y/z (signed Q8.8)
//  output  | out_valid / out_ready    | hit
//  config  | psel/penable/pwrite/...  | box_min_x..z, box_max_x..z at 4*i
//
//  Five register stages: difference, multiply, order near/far, reduce to
//  entry/exit, compare into the output register. One ray is accepted
//  every cycle unless the output stalls; the 17x16 multiplier in stage
//  two sets the clock. Each stage holds its beat while the next is full
//  and stalled, and fills its bubble otherwise. Synchronous reset empties
//  every stage and loads the empty reset box.
// ----------------------------------------------------------------------------
module ray_box_slab_test_unit (
  input  logic                              clk,
  input  logic                              rst,
  // ray input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rbst_pkg::COORD_WIDTH-1:0]  origin_x,
  input  logic [rbst_pkg::COORD_WIDTH-1:0]  origin_y,
  input  logic [rbst_pkg::COORD_WIDTH-1:0]  origin_z,
  input  logic [rbst_pkg::COORD_WIDTH-1:0]  inv_dir_x,
  input  logic [rbst_pkg::COORD_WIDTH-1:0]  inv_dir_y,
  input  logic [rbst_pkg::COORD_WIDTH-1:0]  inv_dir_z,
  // result output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              hit,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rbst_pkg::ADDR_W-1:0]       paddr,
  input  logic [rbst_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rbst_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int NA = rbst_pkg::NUM_AXES;
  localparam int W  = rbst_pkg::COORD_WIDTH;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [W-1:0]                 box_reg [rbst_pkg::NREG];
  logic [rbst_pkg::IDX_W-1:0]   cfg_idx;
  logic                         cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[rbst_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Write a register; drop writes beyond the map
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NA; i++) begin
        box_reg[i]      <= rbst_pkg::BOX_MIN_RESET;
        box_reg[i + NA] <= rbst_pkg::BOX_MAX_RESET;
      end
    end else if (cfg_wr && (32'(cfg_idx) < rbst_pkg::NREG)) begin
      box_reg[cfg_idx] <= pwdata[W-1:0];
    end
  end

  // Read back, zero extended
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      rbst_pkg::REG_BOX_MIN_X: prdata = rbst_pkg::APB_DATA_W'(box_reg[0]);
      rbst_pkg::REG_BOX_MIN_Y: prdata = rbst_pkg::APB_DATA_W'(box_reg[1]);
      rbst_pkg::REG_BOX_MIN_Z: prdata = rbst_pkg::APB_DATA_W'(box_reg[2]);
      rbst_pkg::REG_BOX_MAX_X: prdata = rbst_pkg::APB_DATA_W'(box_reg[3]);
      rbst_pkg::REG_BOX_MAX_Y: prdata = rbst_pkg::APB_DATA_W'(box_reg[4]);
      rbst_pkg::REG_BOX_MAX_Z: prdata = rbst_pkg::APB_DATA_W'(box_reg[5]);
      default:                 prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage valids and back-pressure
  // --------------------------------------------------------------------------
  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5;

  // A stage takes a beat when empty or when its own beat moves on
  assign r5 = !v5 || out_ready;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;

  assign in_ready  = r1;
  assign out_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: corner minus origin, empty-box check
  // --------------------------------------------------------------------------
  rbst_pkg::coord_t org     [NA];
  rbst_pkg::coord_t inv     [NA];
  rbst_pkg::diff_t  dlo     [NA];
  rbst_pkg::diff_t  dhi     [NA];
  logic             empty_c;

  rbst_pkg::diff_t  s1_dlo  [NA];
  rbst_pkg::diff_t  s1_dhi  [NA];
  rbst_pkg::coord_t s1_inv  [NA];
  logic             s1_empty;

  assign org[0] = origin_x;
  assign org[1] = origin_y;
  assign org[2] = origin_z;
  assign inv[0] = inv_dir_x;
  assign inv[1] = inv_dir_y;
  assign inv[2] = inv_dir_z;

  always_comb begin
    empty_c = 1'b0;
    for (int a = 0; a < NA; a++) begin
      dlo[a] = {box_reg[a][W-1], box_reg[a]} - {org[a][W-1], org[a]};
      dhi[a] = {box_reg[a + NA][W-1], box_reg[a + NA]} - {org[a][W-1], org[a]};
      if ($signed(box_reg[a]) > $signed(box_reg[a + NA])) empty_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      s1_dlo   <= dlo;
      s1_dhi   <= dhi;
      s1_inv   <= inv;
      s1_empty <= empty_c;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: exact slab products
  // --------------------------------------------------------------------------
  rbst_pkg::prod_t plo     [NA];
  rbst_pkg::prod_t phi     [NA];
  rbst_pkg::prod_t s2_plo  [NA];
  rbst_pkg::prod_t s2_phi  [NA];
  logic            s2_empty;

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      plo[a] = rbst_pkg::prod_t'(s1_dlo[a]) * rbst_pkg::prod_t'(s1_inv[a]);
      phi[a] = rbst_pkg::prod_t'(s1_dhi[a]) * rbst_pkg::prod_t'(s1_inv[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      s2_plo   <= plo;
      s2_phi   <= phi;
      s2_empty <= s1_empty;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: order each axis into near and far
  // --------------------------------------------------------------------------
  rbst_pkg::prod_t nr      [NA];
  rbst_pkg::prod_t fr      [NA];
  rbst_pkg::prod_t s3_near [NA];
  rbst_pkg::prod_t s3_far  [NA];
  logic            s3_empty;

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      if (s2_plo[a] < s2_phi[a]) begin
        nr[a] = s2_plo[a];
        fr[a] = s2_phi[a];
      end else begin
        nr[a] = s2_phi[a];
        fr[a] = s2_plo[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      s3_near  <= nr;
      s3_far   <= fr;
      s3_empty <= s2_empty;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: entry is the largest near, exit the smallest far
  // --------------------------------------------------------------------------
  rbst_pkg::prod_t entry_c, exit_c;
  rbst_pkg::prod_t s4_entry, s4_exit;
  logic            s4_empty;

  always_comb begin
    entry_c = s3_near[0];
    exit_c  = s3_far[0];
    for (int a = 1; a < NA; a++) begin
      if (s3_near[a] > entry_c) entry_c = s3_near[a];
      if (s3_far[a]  < exit_c)  exit_c  = s3_far[a];
    end
  end

  always_ff @(posedge clk) begin
    if (r4) begin
      s4_entry <= entry_c;
      s4_exit  <= exit_c;
      s4_empty <= s3_empty;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: hit decision into the output register
  // --------------------------------------------------------------------------
  logic hit_c;

  assign hit_c = !s4_empty && (s4_entry < s4_exit) &&
                 (s4_exit > rbst_pkg::prod_t'(0));

  always_ff @(posedge clk) begin
    if (r5) begin
      hit <= hit_c;
    end
  end

endmodule

/* src/rbst_checker.sv */
// ----------------------------------------------------------------------------
// rbst_checker: port-level checks for the slab test unit
// Watches the handshakes and register port over time; bound to the top.
// ----------------------------------------------------------------------------
module rbst_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              hit,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [rbst_pkg::ADDR_W-1:0]       paddr,
  input logic [rbst_pkg::APB_DATA_W-1:0]   pwdata,
  input logic [rbst_pkg::APB_DATA_W-1:0]   prdata
);

  // Pipeline is empty straight after reset
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat present just after reset");

  // A stalled result beat holds its value
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit))
    else $error("stalled result beat changed or vanished");

  // With the sink taking beats, the whole pipeline flows
  a_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // A write to box register 0 (min x) reads back what was written while the address stays on it
  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr == rbst_pkg::ADDR_W'(0))
    |=> (paddr != rbst_pkg::ADDR_W'(0)) ||
        (prdata[rbst_pkg::COORD_WIDTH-1:0] ==
         $past(pwdata[rbst_pkg::COORD_WIDTH-1:0])))
    else $error("box register read back differs from last write");

endmodule

bind ray_box_slab_test_unit rbst_checker u_rbst_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .hit       (hit),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
